[rtl/bhq_pkg.sv]
// bhq_pkg: shared types and fixed widths for the branch history bit queue.
// No dependencies.
package bhq_pkg;

  localparam int OpW        = 2;
  localparam int WordBits   = 64;   // window and append width
  localparam int LenW       = 7;
  localparam int OlderW     = 2;
  localparam int SlotBits   = 10;   // packed pointer width per slot
  localparam int PackedSlots = 4;
  localparam int ChainW     = SlotBits * PackedSlots;
  localparam int GrpW       = 2;
  localparam int PaddrW     = 3;
  localparam int PdataW     = 32;

  // register index, taken from paddr[2]
  localparam logic [0:0] RegDelayedRead = 1'b0;

  typedef enum logic [OpW-1:0] {
    OpAppend  = 2'd0,
    OpRead    = 2'd1,
    OpSnap    = 2'd2,
    OpRestore = 2'd3
  } op_e;

endpackage

[rtl/branch_history_bit_queue.sv]
// branch_history_bit_queue: top level, circular history store, pointer chain,
// read and write paths, APB register. Depends on bhq_pkg.

// Branch history bit queue. History lives in a circular store of STORE_BITS
// bits (a power of two, 256 to 1024), held as 64-bit rows split over two
// banks (even rows, odd rows) so that any 64-bit span touches one row of each
// bank. Every row has a valid flop cleared at reset; a row that was never
// written reads as zeros and is written whole on its first write, so there is
// no clearing pass after reset. Append, snapshot and restore words each write
// the store once in the input stage and can follow back to back; a snapshot
// waits only for room in the result stage. A read word holds the input stage
// until its GROUPS windows have issued, one window per cycle while the result
// stage has room, set by the single read port of each bank. A result word
// passes the input, read-data and output registers. Snapshot and read results
// leave in input order. delayed_read_mode (APB offset 0, bit 0) makes reads
// use the pointer OLD_SLOTS-1-older_in_flight slots back (older_in_flight
// saturates at OLD_SLOTS-1) instead of the newest one.
// Write the register only while the block is idle.
module branch_history_bit_queue #(
  parameter int STORE_BITS = 1024,
  parameter int OLD_SLOTS  = 4,
  parameter int GROUPS     = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bhq_pkg::OpW-1:0]       op_i,
  input  logic [bhq_pkg::WordBits-1:0]  new_bits_i,
  input  logic [bhq_pkg::LenW-1:0]      append_length_i,
  input  logic [bhq_pkg::OlderW-1:0]    older_in_flight_i,
  input  logic [bhq_pkg::ChainW-1:0]    restore_pointers_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bhq_pkg::WordBits-1:0]  history_window_o,
  output logic [bhq_pkg::GrpW-1:0]      group_index_o,
  output logic [bhq_pkg::ChainW-1:0]    pointer_snapshot_o,
  output logic                          last_result_o,
  // APB register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bhq_pkg::PaddrW-1:0]    paddr,
  input  logic [bhq_pkg::PdataW-1:0]    pwdata,
  output logic [bhq_pkg::PdataW-1:0]    prdata,
  output logic                          pready
);
  import bhq_pkg::*;

  localparam int PtrW   = $clog2(STORE_BITS);
  localparam int RowW   = PtrW - 6;            // row index width
  localparam int Rows   = STORE_BITS / WordBits;
  localparam int BankAw = RowW - 1;
  localparam int BankD  = Rows / 2;
  localparam int SlotW  = (OLD_SLOTS > 1) ? $clog2(OLD_SLOTS) : 1;

  typedef logic [PtrW-1:0] ptr_t;

  // ---------------------------------------------------------------------
  // APB register
  // ---------------------------------------------------------------------
  logic delayed_mode_q;
  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2:2] == RegDelayedRead);
  assign prdata  = reg_hit ? {{(PdataW-1){1'b0}}, delayed_mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delayed_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      delayed_mode_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------
  // Input stage (S1)
  // ---------------------------------------------------------------------
  logic                  s1_vld_q;
  op_e                   s1_op_q;
  logic [WordBits-1:0]   s1_bits_q;
  logic [LenW-1:0]       s1_len_q;
  logic [OlderW-1:0]     s1_older_q;
  logic [ChainW-1:0]     s1_restore_q;
  logic [GrpW-1:0]       grp_q;

  logic s2_vld_q, s2_adv, s2_free;
  logic out_vld_q;
  logic is_rd, is_snap, is_plain;
  logic rd_issue, snap_issue, grp_last, s1_done, mem_we;

  always_comb begin
    is_rd    = 1'b0;
    is_snap  = 1'b0;
    is_plain = 1'b0;
    case (s1_op_q)
      OpAppend:  is_plain = 1'b1;
      OpRead:    is_rd    = 1'b1;
      OpSnap:    is_snap  = 1'b1;
      OpRestore: is_plain = 1'b1;
      default:   is_plain = 1'b1;
    endcase
  end

  assign s2_adv     = s2_vld_q && (!out_vld_q || out_ready_i);
  assign s2_free    = !s2_vld_q || s2_adv;
  assign grp_last   = (grp_q == GrpW'(GROUPS - 1));
  assign rd_issue   = s1_vld_q && is_rd && s2_free;
  assign snap_issue = s1_vld_q && is_snap && s2_free;
  assign mem_we     = s1_vld_q && (is_plain || snap_issue);
  assign s1_done    = mem_we || (rd_issue && grp_last);
  assign in_ready_o = !s1_vld_q || s1_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      grp_q    <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_vld_q <= 1'b1;
      end else if (s1_done) begin
        s1_vld_q <= 1'b0;
      end
      if (rd_issue) begin
        grp_q <= grp_last ? '0 : grp_q + GrpW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q      <= op_e'(op_i);
      s1_bits_q    <= new_bits_i;
      s1_len_q     <= append_length_i;
      s1_older_q   <= older_in_flight_i;
      s1_restore_q <= restore_pointers_i;
    end
  end

  // ---------------------------------------------------------------------
  // Pointer chain
  // ---------------------------------------------------------------------
  ptr_t              chain_q   [OLD_SLOTS];
  ptr_t              base_chain[OLD_SLOTS];
  ptr_t              next_chain[OLD_SLOTS];
  logic [ChainW-1:0] snap_pack;
  logic [LenW-1:0]   len_sat;
  ptr_t              wr_ptr;

  assign len_sat = (s1_len_q > LenW'(WordBits)) ? LenW'(WordBits) : s1_len_q;

  for (genvar i = 0; i < OLD_SLOTS; i++) begin : g_restore
    if (i < PackedSlots) begin : g_packed
      logic [PtrW+SlotBits-1:0] fld_ext;
      assign fld_ext = {{PtrW{1'b0}}, s1_restore_q[i*SlotBits +: SlotBits]};
      assign base_chain[i] = (s1_op_q == OpRestore) ? fld_ext[PtrW-1:0] : chain_q[i];
    end else begin : g_unpacked
      assign base_chain[i] = (s1_op_q == OpRestore) ? '0 : chain_q[i];
    end
  end

  assign wr_ptr        = base_chain[0];
  assign next_chain[0] = wr_ptr + PtrW'(len_sat);
  for (genvar i = 1; i < OLD_SLOTS; i++) begin : g_shift
    assign next_chain[i] = base_chain[i-1];
  end

  for (genvar i = 0; i < PackedSlots; i++) begin : g_pack
    if (i < OLD_SLOTS) begin : g_have
      logic [PtrW+SlotBits-1:0] slot_ext;
      assign slot_ext = {{SlotBits{1'b0}}, chain_q[i]};
      assign snap_pack[i*SlotBits +: SlotBits] = slot_ext[SlotBits-1:0];
    end else begin : g_none
      assign snap_pack[i*SlotBits +: SlotBits] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < OLD_SLOTS; i++) chain_q[i] <= '0;
    end else if (mem_we) begin
      for (int i = 0; i < OLD_SLOTS; i++) chain_q[i] <= next_chain[i];
    end
  end

  // read pointer: newest slot, or an older one in delayed mode
  logic [2:0]  older_sat;
  logic [2:0]  rd_slot;
  ptr_t        rd_ptr;
  logic [8:0]  rd_back;
  logic [PtrW+8:0] rd_back_ext;
  ptr_t        rd_start;

  always_comb begin
    older_sat = {1'b0, s1_older_q};
    if (older_sat > 3'(OLD_SLOTS - 1)) older_sat = 3'(OLD_SLOTS - 1);
    rd_slot = 3'(OLD_SLOTS - 1) - older_sat;
  end

  assign rd_ptr      = delayed_mode_q ? chain_q[rd_slot[SlotW-1:0]] : chain_q[0];
  // window g covers [ptr - 64*(g+1), ptr - 64*g)
  assign rd_back     = {3'({1'b0, grp_q}) + 3'd1, 6'd0};
  assign rd_back_ext = {{PtrW{1'b0}}, rd_back};
  assign rd_start    = rd_ptr - rd_back_ext[PtrW-1:0];

  // ---------------------------------------------------------------------
  // History store: two banks of 64-bit rows, valid flop per row
  // ---------------------------------------------------------------------
  ptr_t                acc_pos;
  logic [RowW-1:0]     row_lo, row_hi;
  logic [5:0]          acc_off;
  logic [BankAw-1:0]   addr0, addr1;
  logic [WordBits-1:0] len_mask;
  logic [2*WordBits-1:0] wdata_span, wmask_span;
  logic [WordBits-1:0] wd_lo, wd_hi, wm_lo, wm_hi;
  logic [WordBits-1:0] wd0, wd1, wm0, wm1;
  logic [Rows-1:0]     row_vld_q;

  logic [WordBits-1:0] mem0_q [BankD];
  logic [WordBits-1:0] mem1_q [BankD];
  logic [WordBits-1:0] rd0_q, rd1_q;

  assign acc_pos = is_rd ? rd_start : wr_ptr;
  assign row_lo  = acc_pos[PtrW-1:6];
  assign row_hi  = row_lo + RowW'(1);
  assign acc_off = acc_pos[5:0];
  assign addr0   = row_lo[0] ? row_hi[RowW-1:1] : row_lo[RowW-1:1];
  assign addr1   = row_lo[0] ? row_lo[RowW-1:1] : row_hi[RowW-1:1];

  assign len_mask   = len_sat[6] ? '1 : ((WordBits'(1) << len_sat[5:0]) - WordBits'(1));
  assign wdata_span = {{WordBits{1'b0}}, s1_bits_q & len_mask} << acc_off;
  assign wmask_span = {{WordBits{1'b0}}, len_mask} << acc_off;

  // a row never written gets all its bits, zero outside the new ones
  assign wd_lo = wdata_span[WordBits-1:0];
  assign wd_hi = wdata_span[2*WordBits-1:WordBits];
  assign wm_lo = row_vld_q[row_lo] ? wmask_span[WordBits-1:0] : '1;
  assign wm_hi = row_vld_q[row_hi] ? wmask_span[2*WordBits-1:WordBits] : '1;

  assign wd0 = row_lo[0] ? wd_hi : wd_lo;
  assign wm0 = row_lo[0] ? wm_hi : wm_lo;
  assign wd1 = row_lo[0] ? wd_lo : wd_hi;
  assign wm1 = row_lo[0] ? wm_lo : wm_hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (mem_we) begin
      row_vld_q[row_lo] <= 1'b1;
      row_vld_q[row_hi] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int b = 0; b < WordBits; b++) begin
        if (wm0[b]) mem0_q[addr0][b] <= wd0[b];
        if (wm1[b]) mem1_q[addr1][b] <= wd1[b];
      end
    end
    if (rd_issue) begin
      rd0_q <= mem0_q[addr0];
      rd1_q <= mem1_q[addr1];
    end
  end

  // ---------------------------------------------------------------------
  // Read-data stage (S2)
  // ---------------------------------------------------------------------
  logic              s2_is_rd_q, s2_last_q, s2_lob_q, s2_vlo_q, s2_vhi_q;
  logic [GrpW-1:0]   s2_grp_q;
  logic [5:0]        s2_off_q;
  logic [ChainW-1:0] s2_snap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (rd_issue || snap_issue) begin
      s2_vld_q <= 1'b1;
    end else if (s2_adv) begin
      s2_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue || snap_issue) begin
      s2_is_rd_q <= is_rd;
      s2_last_q  <= snap_issue || grp_last;
      s2_grp_q   <= is_rd ? grp_q : '0;
      s2_off_q   <= acc_off;
      s2_lob_q   <= row_lo[0];
      s2_vlo_q   <= row_vld_q[row_lo];
      s2_vhi_q   <= row_vld_q[row_hi];
      s2_snap_q  <= snap_pack;
    end
  end

  logic [WordBits-1:0]   lo_word, hi_word, win;
  logic [2*WordBits-1:0] rd_span;

  assign lo_word = s2_vlo_q ? (s2_lob_q ? rd1_q : rd0_q) : '0;
  assign hi_word = s2_vhi_q ? (s2_lob_q ? rd0_q : rd1_q) : '0;
  assign rd_span = {hi_word, lo_word} >> s2_off_q;

  // most recent bit first
  always_comb begin
    for (int k = 0; k < WordBits; k++) begin
      win[k] = s2_is_rd_q ? rd_span[WordBits-1-k] : 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s2_adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      history_window_o   <= win;
      group_index_o      <= s2_grp_q;
      pointer_snapshot_o <= s2_snap_q;
      last_result_o      <= s2_last_q;
    end
  end

  assign out_valid_o = out_vld_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && rd_issue))
    else $error("store written and read in the same cycle");

  a_read_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_issue && !grp_last) |-> !in_ready_o)
    else $error("input taken before the last window of a read issued");

  a_last_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_result_o && group_index_o != '0)
      |-> (group_index_o == GrpW'(GROUPS - 1)))
    else $error("last window flagged on the wrong group");

  a_window_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_issue || snap_issue) |=> s2_vld_q)
    else $error("issued result lost before the read-data stage");

endmodule

[sim/branch_history_bit_queue_test.sv]
// branch_history_bit_queue_test: self-checking testbench for the branch history bit queue.
// Needs bhq_pkg and branch_history_bit_queue; it keeps its own copy of the history store
// and pointer chain and checks every result word against it.
module branch_history_bit_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bhq_pkg::*;

  // Block configuration, kept at the defaults of the top level.
  localparam int HistBits     = 1024;
  localparam int ChainSlots   = 4;
  localparam int WindowGroups = 4;

  // Watchdog: cycles with no word moving on either side, and a cap on the whole run.
  localparam int QuietLimit  = 2000;
  localparam int RunLimit    = 200000;
  // Cycles to let pass after the last result before touching the register:
  // an append word may still sit in the three-stage pipe with nothing to show for it.
  localparam int SettleCycles = 6;

  typedef struct {
    logic [WordBits-1:0] window;
    logic [GrpW-1:0]     group;
    logic [ChainW-1:0]   pointers;
    logic                last;
  } result_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [OpW-1:0]       op_i;
  logic [WordBits-1:0]  new_bits_i;
  logic [LenW-1:0]      append_length_i;
  logic [OlderW-1:0]    older_in_flight_i;
  logic [ChainW-1:0]    restore_pointers_i;

  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [WordBits-1:0]  history_window_o;
  logic [GrpW-1:0]      group_index_o;
  logic [ChainW-1:0]    pointer_snapshot_o;
  logic                 last_result_o;

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PaddrW-1:0]    paddr;
  logic [PdataW-1:0]    pwdata;
  logic [PdataW-1:0]    prdata;
  logic                 pready;

  branch_history_bit_queue #(
    .STORE_BITS(HistBits),
    .OLD_SLOTS (ChainSlots),
    .GROUPS    (WindowGroups)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .new_bits_i        (new_bits_i),
    .append_length_i   (append_length_i),
    .older_in_flight_i (older_in_flight_i),
    .restore_pointers_i(restore_pointers_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .history_window_o  (history_window_o),
    .group_index_o     (group_index_o),
    .pointer_snapshot_o(pointer_snapshot_o),
    .last_result_o     (last_result_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 2 ns clock, rising edges at odd ns.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Expected state: our own copy of the history bits, the pointer chain and the
  // read-mode register. Updated on every accepted input word.
  // ---------------------------------------------------------------------------
  logic                  history_copy [HistBits];
  logic [SlotBits-1:0]   chain_copy   [ChainSlots];
  logic                  delayed_mode_copy;

  result_word_t          awaited_results [$];   // in output order
  logic [ChainW-1:0]     saved_chains    [$];   // snapshots seen, reused for restores

  int  error_count;
  int  words_accepted;
  int  results_checked;
  int  op_count [4];
  int  max_awaited;

  // Shared between the stimulus and the receiver process.
  bit  idle_enabled;
  int  ready_hold_request;

  function automatic logic [ChainW-1:0] packed_chain();
    logic [ChainW-1:0] v;
    v = '0;
    for (int i = 0; i < ChainSlots && i < PackedSlots; i++)
      v[i*SlotBits +: SlotBits] = chain_copy[i];
    return v;
  endfunction

  // Write up to 64 bits at the newest pointer, then age the chain by one slot.
  function automatic void append_history(logic [WordBits-1:0] bits, logic [LenW-1:0] len);
    int n;
    int w;
    n = (len > WordBits) ? WordBits : int'(len);
    w = chain_copy[0];
    for (int i = 0; i < n; i++) history_copy[(w + i) % HistBits] = bits[i];
    for (int i = ChainSlots - 1; i > 0; i--) chain_copy[i] = chain_copy[i-1];
    chain_copy[0] = SlotBits'((w + n) % HistBits);
  endfunction

  // 64 bits ending just before position ptr (may be negative), newest in bit 0.
  function automatic logic [WordBits-1:0] window_ending_at(int ptr);
    logic [WordBits-1:0] v;
    for (int k = 0; k < WordBits; k++)
      v[k] = history_copy[((ptr - 1 - k) % HistBits + HistBits) % HistBits];
    return v;
  endfunction

  // Work out the result words an accepted input word causes and advance the copy.
  function automatic void apply_word_to_history(op_e op, logic [WordBits-1:0] bits,
                                                logic [LenW-1:0] len, logic [OlderW-1:0] older,
                                                logic [ChainW-1:0] restore);
    logic [ChainW-1:0] before_op;
    result_word_t      r;
    int                slot;
    int                ptr;
    before_op = packed_chain();
    case (op)
      OpAppend: begin
        append_history(bits, len);
      end
      OpRead: begin
        if (delayed_mode_copy) begin
          // in-flight count saturates at the oldest slot distance
          slot = (int'(older) > ChainSlots - 1) ? 0 : ChainSlots - 1 - int'(older);
        end else begin
          slot = 0;
        end
        ptr = chain_copy[slot];
        for (int g = 0; g < WindowGroups; g++) begin
          r.window   = window_ending_at(ptr - g * WordBits);
          r.group    = GrpW'(g);
          r.pointers = before_op;
          r.last     = (g == WindowGroups - 1);
          awaited_results.push_back(r);
        end
      end
      OpSnap: begin
        r.window   = '0;
        r.group    = '0;
        r.pointers = before_op;
        r.last     = 1'b1;
        awaited_results.push_back(r);
        saved_chains.push_back(before_op);
        if (saved_chains.size() > 16) void'(saved_chains.pop_front());
        append_history(bits, len);
      end
      default: begin
        // restore: slots past the packed field come back as zero
        for (int i = 0; i < ChainSlots; i++) begin
          if (i < PackedSlots) chain_copy[i] = SlotBits'(restore[i*SlotBits +: SlotBits] % HistBits);
          else chain_copy[i] = '0;
        end
        append_history(bits, len);
      end
    endcase
    if (awaited_results.size() > max_awaited) max_awaited = awaited_results.size();
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Called at a falling edge, returns at the falling edge after the
  // word is taken, with valid still high so that a back-to-back word needs no
  // second assignment in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_word(op_e op, logic [WordBits-1:0] bits, logic [LenW-1:0] len,
                           logic [OlderW-1:0] older, logic [ChainW-1:0] restore);
    if (idle_enabled) begin
      while ($urandom_range(99) < 33) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i         = 1'b1;
    op_i               = op;
    new_bits_i         = bits;
    append_length_i    = len;
    older_in_flight_i  = older;
    restore_pointers_i = restore;
    do @(posedge clk_i); while (!in_ready_o);
    apply_word_to_history(op, bits, len, older, restore);
    words_accepted++;
    op_count[op]++;
    @(negedge clk_i);
  endtask

  task automatic send_random_word();
    op_e               op;
    logic [LenW-1:0]   len;
    logic [ChainW-1:0] restore;
    int                pick;
    pick = $urandom_range(99);
    if (pick < 35)      op = OpAppend;
    else if (pick < 65) op = OpRead;
    else if (pick < 82) op = OpSnap;
    else                op = OpRestore;
    // mostly legal lengths, one in ten above 64 to hit the saturation
    if ($urandom_range(9) == 0) len = LenW'($urandom_range(127, 65));
    else len = LenW'($urandom_range(WordBits));
    // restores mostly bring back a real checkpoint, sometimes any 40 bits
    if (saved_chains.size() > 0 && $urandom_range(99) < 70)
      restore = saved_chains[$urandom_range(saved_chains.size() - 1)];
    else
      restore = {8'($urandom_range(255)), 32'($urandom)};
    send_word(op, {$urandom, $urandom}, len, OlderW'($urandom_range(3)), restore);
  endtask

  // Stop offering, wait for every expected result, then let the pipe empty.
  // Returns at a falling edge.
  task automatic wait_until_drained();
    in_valid_i = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // APB write then read-back of the read-mode register; only while idle.
  task automatic set_delayed_read_mode(logic mode);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PaddrW'({RegDelayedRead, 2'b00});
    pwdata  = PdataW'(mode);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    delayed_mode_copy = mode;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata !== PdataW'(delayed_mode_copy)) begin
      error_count++;
      $display("%0t: delayed_read_mode read-back mismatch: expected %h, got %h",
               $time, PdataW'(delayed_mode_copy), prdata);
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready idles at random, or holds off for a requested stretch.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : result_receiver
    int hold_left;
    if (ready_hold_request > 0) begin
      hold_left          = ready_hold_request;
      ready_hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else if (idle_enabled) begin
      out_ready_i = ($urandom_range(99) >= 33);
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // Every accepted result word against the oldest expectation.
  always @(posedge clk_i) begin : result_checker
    result_word_t oldest;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        error_count++;
        $display("%0t: result word with nothing expected: window %h group %0d",
                 $time, history_window_o, group_index_o);
        $display("%0t:   pointers %h last %0d", $time, pointer_snapshot_o, last_result_o);
      end else begin
        oldest = awaited_results.pop_front();
        results_checked++;
        if (history_window_o !== oldest.window) begin
          error_count++;
          $display("%0t: history_window mismatch: expected %h, got %h",
                   $time, oldest.window, history_window_o);
        end
        if (group_index_o !== oldest.group) begin
          error_count++;
          $display("%0t: group_index mismatch: expected %0d, got %0d",
                   $time, oldest.group, group_index_o);
        end
        if (pointer_snapshot_o !== oldest.pointers) begin
          error_count++;
          $display("%0t: pointer_snapshot mismatch: expected %h, got %h",
                   $time, oldest.pointers, pointer_snapshot_o);
        end
        if (last_result_o !== oldest.last) begin
          error_count++;
          $display("%0t: last_result mismatch: expected %0d, got %0d",
                   $time, oldest.last, last_result_o);
        end
      end
    end
  end

  // Watchdog: ends the run if nothing moves for too long or the run overstays.
  initial begin : watchdog
    int quiet_cycles;
    int run_cycles;
    quiet_cycles = 0;
    run_cycles   = 0;
    while (quiet_cycles < QuietLimit && run_cycles < RunLimit) begin
      @(posedge clk_i);
      run_cycles++;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: timeout, %0d results still expected", $time, awaited_results.size());
    $display("branch_history_bit_queue test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Mode 0: empty store, length extremes and saturation, snapshot, restore
  // of an all-ones chain so that the next append wraps past the end.
  task automatic test_directed_words();
    idle_enabled = 1'b0;
    send_word(OpRead,    '0,                    7'd0,   2'd0, '0);
    send_word(OpAppend,  '1,                    7'd0,   2'd0, '0);
    send_word(OpAppend,  '1,                    7'd64,  2'd3, '1);
    send_word(OpAppend,  64'hA5A5_5A5A_F0F0_0F0F, 7'd127, 2'd0, '0);
    send_word(OpAppend,  64'h8000_0000_0000_0001, 7'd65,  2'd1, '0);
    send_word(OpAppend,  64'h1,                 7'd1,   2'd2, '0);
    send_word(OpSnap,    64'h0123_4567_89AB_CDEF, 7'd64,  2'd0, '0);
    send_word(OpRead,    '0,                    7'd0,   2'd3, '1);
    send_word(OpRestore, 64'hDEAD_BEEF_CAFE_F00D, 7'd64,  2'd0, '1);
    send_word(OpRead,    '1,                    7'd127, 2'd0, '0);
    send_word(OpSnap,    '0,                    7'd0,   2'd0, '1);
    send_word(OpRestore, '1,                    7'd0,   2'd0, '0);
    send_word(OpSnap,    '1,                    7'd33,  2'd0, '0);
    send_word(OpRead,    '0,                    7'd0,   2'd0, '0);
    wait_until_drained();
  endtask

  // Mode 1: every in-flight count picks a different slot of the chain.
  task automatic test_delayed_reads();
    set_delayed_read_mode(1'b1);
    send_word(OpAppend, 64'hFFFF_0000_FFFF_0000, 7'd40, 2'd0, '0);
    for (int older = 0; older < 4; older++) send_word(OpRead, '0, 7'd0, OlderW'(older), '0);
    send_word(OpSnap,    64'h5555_AAAA_5555_AAAA, 7'd64, 2'd0, '0);
    send_word(OpRestore, 64'h3, 7'd2, 2'd0, 40'h00_3FF0_0401);
    send_word(OpRead,    '0,    7'd0, 2'd2, '0);
    wait_until_drained();
  endtask

  task automatic test_random_with_idling(logic mode, int count);
    set_delayed_read_mode(mode);
    idle_enabled = 1'b1;
    repeat (count) send_random_word();
    wait_until_drained();
  endtask

  // A long stretch with both sides always ready.
  task automatic test_random_full_rate(logic mode, int count);
    set_delayed_read_mode(mode);
    idle_enabled = 1'b0;
    repeat (count) send_random_word();
    wait_until_drained();
  endtask

  // Receiver holds off while reads and snapshots keep coming, so the result
  // stage fills and the input stalls; then the sender waits for everything.
  task automatic test_output_backpressure();
    idle_enabled = 1'b0;
    @(posedge clk_i);
    ready_hold_request = 80;
    @(negedge clk_i);
    repeat (24) begin
      if ($urandom_range(3) == 0) send_word(OpSnap, {$urandom, $urandom}, 7'($urandom_range(64)),
                                            2'd0, '0);
      else send_word(OpRead, '0, 7'd0, OlderW'($urandom_range(3)), '0);
    end
    wait_until_drained();
    idle_enabled = 1'b1;
  endtask

  initial begin : run_tests
    error_count        = 0;
    words_accepted     = 0;
    results_checked    = 0;
    max_awaited        = 0;
    op_count           = '{default: 0};
    idle_enabled       = 1'b0;
    ready_hold_request = 0;
    for (int i = 0; i < HistBits; i++) history_copy[i] = 1'b0;
    for (int i = 0; i < ChainSlots; i++) chain_copy[i] = '0;
    delayed_mode_copy  = 1'b0;

    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    op_i               = OpAppend;
    new_bits_i         = '0;
    append_length_i    = '0;
    older_in_flight_i  = '0;
    restore_pointers_i = '0;
    out_ready_i        = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_delayed_read_mode(1'b0);
    test_directed_words();
    test_delayed_reads();
    test_random_with_idling(1'b0, 160);
    test_random_full_rate(1'b1, 150);
    test_output_backpressure();
    test_random_with_idling(1'b1, 90);
    test_random_with_idling(1'b0, 90);

    wait_until_drained();
    $display("Covered %0d words (append %0d, read %0d, snapshot %0d, restore %0d),",
             words_accepted, op_count[OpAppend], op_count[OpRead], op_count[OpSnap],
             op_count[OpRestore]);
    $display("%0d results checked over both read modes, saturated lengths and store wrap,",
             results_checked);
    $display("with up to %0d results queued at once.", max_awaited);
    if (error_count == 0) begin
      $display("branch_history_bit_queue test passed");
    end else begin
      $display("branch_history_bit_queue test failed");
    end
    $finish;
  end

endmodule
